/* rtl/dwarf_pointer_encoder_assert.svh */
// Assertion macros for the DWARF pointer encoder.
// Used by rtl/dwarf_pointer_encoder.sv; expects clk and arst_n in scope.
`ifndef DWARF_POINTER_ENCODER_ASSERT_SVH
`define DWARF_POINTER_ENCODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a property at every rising clock edge outside reset.
`define DPE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("dwarf_pointer_encoder assertion failed");
// Check that a condition never holds outside reset.
`define DPE_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error("dwarf_pointer_encoder forbidden condition seen");
`else
`define DPE_ASSERT(lbl, prop)
`define DPE_NEVER(lbl, cond)
`endif
`endif

/* rtl/dpe_pkg.sv */
// Package for the DWARF pointer encoder: payload structs, format codes,
// microprogram word type and the microprogram ROM. No dependencies.
package dpe_pkg;

	typedef struct packed {
		logic [7:0]         encoding;
		logic signed [63:0] value;
	} dpe_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} dpe_out_t;

	// Format codes, low nibble of the encoding byte
	localparam logic [3:0] FMT_ABS   = 4'h0;
	localparam logic [3:0] FMT_ULEB  = 4'h1;
	localparam logic [3:0] FMT_U16   = 4'h2;
	localparam logic [3:0] FMT_U32   = 4'h3;
	localparam logic [3:0] FMT_U64   = 4'h4;
	localparam logic [3:0] FMT_SLEB  = 4'h9;
	localparam logic [3:0] FMT_S16   = 4'hA;
	localparam logic [3:0] FMT_S32   = 4'hB;
	localparam logic [3:0] FMT_S64   = 4'hC;

	localparam int unsigned CNT_W = 3;

	// Microprogram address doubles as the step counter
	typedef enum logic [1:0] {
		UPC_DISPATCH,
		UPC_FIX,
		UPC_ULEB,
		UPC_SLEB
	} upc_t;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_FIX,
		EMIT_ULEB,
		EMIT_SLEB
	} emit_t;

	typedef struct packed {
		logic  take_in;   // step accepts an input item and dispatches on format
		emit_t emit;      // byte former and shifter selection
		upc_t  next_upc;  // jump target once the last byte is taken
	} uword_t;

	function automatic uword_t dpe_rom(upc_t addr);
		uword_t w;
		w = '{take_in: 1'b0, emit: EMIT_NONE, next_upc: UPC_DISPATCH};
		case (addr)
			UPC_DISPATCH: w = '{take_in: 1'b1, emit: EMIT_NONE, next_upc: UPC_DISPATCH};
			UPC_FIX:      w = '{take_in: 1'b0, emit: EMIT_FIX,  next_upc: UPC_DISPATCH};
			UPC_ULEB:     w = '{take_in: 1'b0, emit: EMIT_ULEB, next_upc: UPC_DISPATCH};
			UPC_SLEB:     w = '{take_in: 1'b0, emit: EMIT_SLEB, next_upc: UPC_DISPATCH};
			default:      w = '{take_in: 1'b0, emit: EMIT_NONE, next_upc: UPC_DISPATCH};
		endcase
		return w;
	endfunction

endpackage

/* rtl/dwarf_pointer_encoder.sv */
// DWARF pointer encoder top level: microcoded sequencer over a 64-bit shifter.
// Depends on rtl/dpe_pkg.sv and rtl/dwarf_pointer_encoder_assert.svh.
//
//   channel | dir | handshake          | payload
//   in      | in  | in_valid/in_ready   | dpe_in_t  {encoding, value}
//   out     | out | out_valid/out_ready | dpe_out_t {out_byte, last}
//
// Each item starts with a dispatch step, then one byte per cycle follows while
// out_ready is high. A fixed field gives 2, 4 or 8 bytes, LEB128 gives 1 to 10,
// an unknown format gives none. The single byte-wide output path sets the rate.
// Reset clears the step counter to the dispatch step; the shifter needs none.
// A stalled output holds the step, shifter and count, so the byte stays put.
// Input is taken only in the dispatch step; one item is in flight at a time.
`include "dwarf_pointer_encoder_assert.svh"
module dwarf_pointer_encoder #(
	parameter int POINTER_BYTES = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  dpe_pkg::dpe_in_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output dpe_pkg::dpe_out_t out_data
);
	import dpe_pkg::*;

	// Last byte index of an absolute pointer
	localparam logic [CNT_W-1:0] ABS_LAST = (POINTER_BYTES <= 4) ? CNT_W'(3) : CNT_W'(7);

	upc_t             upc_q, upc_d;
	uword_t           uw;
	logic [63:0]      sh_q, sh_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [63:0]      sh_logic, sh_arith;
	logic             in_fire, out_fire;
	logic             is_last;
	logic             leb_emit;
	logic [3:0]       fmt;

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UPC_DISPATCH;
		end else begin
			upc_q <= upc_d;
		end
	end

	// Datapath registers, no reset needed
	always_ff @(posedge clk) begin
		sh_q  <= sh_d;
		cnt_q <= cnt_d;
	end

	always_comb begin
		uw        = dpe_rom(upc_q);
		fmt       = in_data.encoding[3:0];
		in_ready  = uw.take_in;
		out_valid = (uw.emit != EMIT_NONE);
		leb_emit  = (uw.emit == EMIT_ULEB) || (uw.emit == EMIT_SLEB);
		in_fire   = in_valid && in_ready;
		out_fire  = out_valid && out_ready;
		sh_logic  = sh_q >> 7;
		sh_arith  = 64'($signed(sh_q) >>> 7);
		upc_d     = upc_q;
		sh_d      = sh_q;
		cnt_d     = cnt_q;
		is_last   = 1'b0;
		out_data  = '{out_byte: 8'h00, last: 1'b0};

		// Form the byte and pick the shift for this step
		case (uw.emit)
			EMIT_FIX: begin
				is_last  = (cnt_q == '0);
				out_data = '{out_byte: sh_q[7:0], last: is_last};
			end
			EMIT_ULEB: begin
				is_last  = (sh_logic == '0);
				out_data = '{out_byte: {!is_last, sh_q[6:0]}, last: is_last};
			end
			EMIT_SLEB: begin
				// Stop once the remaining bits are pure sign, matching bit 6
				is_last  = ((sh_arith == '0) && !sh_q[6]) ||
				           ((sh_arith == '1) && sh_q[6]);
				out_data = '{out_byte: {!is_last, sh_q[6:0]}, last: is_last};
			end
			default: begin
				is_last = 1'b0;
			end
		endcase

		// Dispatch: load the value and jump on format
		if (in_fire) begin
			sh_d  = in_data.value;
			cnt_d = '0;
			case (fmt)
				FMT_ABS: begin
					upc_d = UPC_FIX;
					cnt_d = ABS_LAST;
				end
				FMT_U16, FMT_S16: begin
					upc_d = UPC_FIX;
					cnt_d = CNT_W'(1);
				end
				FMT_U32, FMT_S32: begin
					upc_d = UPC_FIX;
					cnt_d = CNT_W'(3);
				end
				FMT_U64, FMT_S64: begin
					upc_d = UPC_FIX;
					cnt_d = CNT_W'(7);
				end
				FMT_ULEB: upc_d = UPC_ULEB;
				FMT_SLEB: upc_d = UPC_SLEB;
				default:  upc_d = UPC_DISPATCH; // unknown format: drop
			endcase
		end

		// Advance on every byte taken; jump back after the last
		if (out_fire) begin
			cnt_d = cnt_q - CNT_W'(1);
			case (uw.emit)
				EMIT_FIX:  sh_d = sh_q >> 8;
				EMIT_ULEB: sh_d = sh_logic;
				EMIT_SLEB: sh_d = sh_arith;
				default:   sh_d = sh_q;
			endcase
			if (is_last) begin
				upc_d = uw.next_upc;
			end
		end
	end

	// Never take input while a byte is offered
	`DPE_NEVER(a_no_overlap, in_ready && out_valid)
	// LEB128 continuation bit is the inverse of the last flag
	`DPE_ASSERT(a_leb_cont, (out_valid && leb_emit) |-> (out_data.out_byte[7] != out_data.last))
	// Fixed field ends exactly when the count runs out
	`DPE_ASSERT(a_fix_last, (out_valid && upc_q == UPC_FIX) |-> (out_data.last == (cnt_q == '0)))
	// Return to dispatch right after the last byte is taken
	`DPE_ASSERT(a_back_to_dispatch, (out_valid && out_ready && out_data.last) |=> in_ready)

endmodule
